[sv/crc_pkg.sv]
package crc_pkg;

    localparam int HIST_DEPTH_DEF = 3;
    localparam int WAVE_COUNT_DEF = 2;
    localparam int MAX_HARM_DEF   = 8;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 31;
    localparam int RADICAND_W = 64;
    localparam int ROOT_W     = 32;

    typedef enum logic [2:0] {
        REG_QM     = 3'd0,
        REG_MASS   = 3'd1,
        REG_HCOUNT = 3'd2,
        REG_FREQ_A = 3'd3,
        REG_FREQ_B = 3'd4,
        REG_MODE_A = 3'd5,
        REG_MODE_B = 3'd6
    } crc_reg_t;

    typedef enum logic [1:0] {
        CMD_INIT = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_EVAL = 2'd2,
        CMD_NONE = 2'd3
    } crc_cmd_t;

    // status of an iterative unit toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } crc_unit_st_t;

    // saturate a quotient magnitude with its sign to 32-bit signed
    function automatic logic signed [31:0] sat_quot(input logic [63:0] q, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (q > 64'h0000_0000_8000_0000) r = 32'sh8000_0000;
            else r = 32'(~q[31:0] + 32'd1);
        end else begin
            if (q > 64'h0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
            else r = 32'(q[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_res(input logic signed [53:0] v);
        logic signed [31:0] r;
        if (v > 54'sd2147483647) r = 32'sh7FFF_FFFF;
        else if (v < -54'sd2147483648) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic flipped(input logic signed [31:0] a, input logic signed [31:0] b);
        return ((a < 0) && (b > 0)) || ((a > 0) && (b < 0));
    endfunction

endpackage

[sv/cyclotron_resonance_crossing_core.sv]
// Cyclotron resonance crossing tracker for one marker.
// Input channel (s_*): one transfer per command. Initialize (running set) loads the
// field-magnitude history and each wave's resonance tables up to the harmonic count;
// push shifts a new |B| into the history; evaluate checks one wave and returns
// one result on the m_* channel: kick count and the harmonic crossed (-1 if none).
// Initialize with running clear and the unused command code are taken and dropped.
// Configuration: cfg_valid/cfg_ready write port, always ready, register by index;
// write only while the block is idle.
// Processing: one item at a time. Push uses the shared multiplier and the square-root
// unit; evaluate and initialize go on through the divider, for the parallel wave number
// and then the doppler term, and then step through the harmonics one by one; initialize
// does so for every wave. Evaluate on a still history or an absent wave skips the divider.
// The result sits in an output register; the next item is taken while it waits.
// A stalled receiver holds the result; a following evaluate then waits in its
// last state, with s_ready low, until the output register frees.
// Reset (aresetn low, synchronous): registers return to defaults, history clears,
// output is empty. Table contents are undefined until an initialize fills them.
module cyclotron_resonance_crossing_core
    import crc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
    parameter int WAVE_COUNT    = WAVE_COUNT_DEF,
    parameter int MAX_HARMONICS = MAX_HARM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic               s_running,
    input  logic signed [31:0] s_field_radial,
    input  logic signed [31:0] s_field_toroidal,
    input  logic signed [31:0] s_field_vertical,
    input  logic [30:0]        s_major_radius,
    input  logic signed [31:0] s_parallel_momentum,
    input  logic               s_wave_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kick_count,
    output logic signed [4:0]  m_resonance_level
);

    localparam int TABLE_DEPTH = WAVE_COUNT * MAX_HARMONICS;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int HC_W        = $clog2(MAX_HARMONICS + 1);

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_SQ      = 15'h0002,
        S_ACC     = 15'h0004,
        S_RT_GO   = 15'h0008,
        S_RT_WAIT = 15'h0010,
        S_QB_MUL  = 15'h0020,
        S_QB_SHF  = 15'h0040,
        S_KP_GO   = 15'h0080,
        S_KP_WAIT = 15'h0100,
        S_DM_MUL  = 15'h0200,
        S_DD_GO   = 15'h0400,
        S_DD_WAIT = 15'h0800,
        S_H_RD    = 15'h1000,
        S_H_RES   = 15'h2000,
        S_OUT     = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [31:0] qm_reg;
    logic [30:0]        mass_reg;
    logic [3:0]         hcount_reg;
    logic signed [31:0] freq_a_reg, freq_b_reg;
    logic signed [7:0]  mode_a_reg, mode_b_reg;

    // latched item
    crc_cmd_t           cmd_reg;
    logic signed [31:0] fld_reg [3];
    logic [30:0]        radius_reg;
    logic signed [31:0] ppar_reg;
    logic               wave_in_reg;

    // working registers
    logic [1:0]         sq_idx_reg;
    logic [63:0]        sum_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]        b_reg;
    logic signed [47:0] qb_reg;
    logic signed [31:0] kpara_reg;
    logic signed [31:0] dop_reg;
    logic signed [51:0] lqb_reg;
    logic               div_neg_reg;
    logic               w_reg;
    logic [HC_W-1:0]    hidx_reg;
    logic signed [31:0] np_reg, pp_reg;
    logic [31:0]        hist_reg [HISTORY_DEPTH];
    logic signed [31:0] minus_tbl [TABLE_DEPTH];
    logic signed [31:0] plus_tbl [TABLE_DEPTH];

    logic [1:0]         res_kick_reg;
    logic [4:0]         res_level_reg;
    logic               m_valid_reg;
    logic [1:0]         m_kick_reg;
    logic [4:0]         m_level_reg;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;

    // iterative units
    logic               rt_start, div_start;
    crc_unit_st_t       rt_stat, div_stat;
    logic [ROOT_W-1:0]  rt_root;
    logic [63:0]        div_dividend, div_quot;
    logic [30:0]        div_divisor;

    logic               out_free;
    logic               still;
    logic               wave_oor;
    logic [HC_W-1:0]    hc;
    logic               h_last;
    logic               wave_last;
    state_t             wave_end_st;
    logic signed [31:0] freq_sel;
    logic signed [7:0]  mode_sel;
    logic [7:0]         mode_abs;
    logic [63:0]        prod_abs;
    logic [IDX_W-1:0]   tbl_idx;
    logic signed [53:0] res_base;
    logic signed [31:0] nc, pc;
    logic               hit;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    assign still    = (hist_reg[0] == hist_reg[1]) && (hist_reg[1] == hist_reg[2]);
    assign wave_oor = (int'(wave_in_reg) >= WAVE_COUNT);
    assign hc       = (hcount_reg > 4'(MAX_HARMONICS)) ? HC_W'(MAX_HARMONICS)
                                                       : HC_W'(hcount_reg);
    assign h_last   = (HC_W'(hidx_reg + HC_W'(1)) == hc);
    assign wave_last = (cmd_reg == CMD_EVAL) || (int'(w_reg) == WAVE_COUNT - 1);

    always_comb begin
        if (cmd_reg == CMD_EVAL) wave_end_st = S_OUT;
        else if (wave_last)      wave_end_st = S_IDLE;
        else                     wave_end_st = S_KP_GO;
    end

    assign freq_sel = w_reg ? freq_b_reg : freq_a_reg;
    assign mode_sel = w_reg ? mode_b_reg : mode_a_reg;
    assign mode_abs = mode_sel[7] ? (~mode_sel + 8'd1) : mode_sel;
    assign prod_abs = prod_reg[63] ? (~prod_reg + 64'd1) : prod_reg;
    assign tbl_idx  = IDX_W'(int'(w_reg) * MAX_HARMONICS + int'(hidx_reg));

    // resonance values: freq - l*qm*|B| -/+ doppler
    assign res_base = 54'(freq_sel) - 54'(lqb_reg);
    assign nc       = sat_res(res_base - 54'(dop_reg));
    assign pc       = sat_res(res_base + 54'(dop_reg));
    assign hit      = (cmd_reg == CMD_EVAL) && flipped(np_reg, nc);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ: begin
                mul_a = 33'(fld_reg[sq_idx_reg]);
                mul_b = 33'(fld_reg[sq_idx_reg]);
            end
            S_QB_MUL: begin
                mul_a = 33'(qm_reg);
                mul_b = {1'b0, b_reg};
            end
            S_DM_MUL: begin
                mul_a = 33'(kpara_reg);
                mul_b = 33'(ppar_reg);
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // iterative unit hookup
    assign rt_start  = (state_reg == S_RT_GO);
    assign div_start = (state_reg == S_KP_GO) || (state_reg == S_DD_GO);
    always_comb begin
        if (state_reg == S_KP_GO) begin
            div_dividend = {24'd0, mode_abs, 32'd0};
            div_divisor  = (radius_reg == '0) ? 31'd1 : radius_reg;
        end else begin
            div_dividend = prod_abs;
            div_divisor  = (mass_reg == '0) ? 31'd1 : mass_reg;
        end
    end

    crc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rt_start),
        .radicand (sum_reg),
        .stat     (rt_stat),
        .root     (rt_root)
    );

    crc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (crc_cmd_t'(s_command) == CMD_NONE ||
                        (crc_cmd_t'(s_command) == CMD_INIT && !s_running))
                        state_next = S_IDLE;
                    else
                        state_next = S_SQ;
                end
            end
            S_SQ:      state_next = S_ACC;
            S_ACC:     state_next = (sq_idx_reg == 2'd2) ? S_RT_GO : S_SQ;
            S_RT_GO:   state_next = S_RT_WAIT;
            S_RT_WAIT: begin
                if (rt_stat.done) state_next = (cmd_reg == CMD_PUSH) ? S_IDLE : S_QB_MUL;
            end
            S_QB_MUL:  state_next = S_QB_SHF;
            S_QB_SHF: begin
                if (cmd_reg == CMD_EVAL && (still || wave_oor)) state_next = S_OUT;
                else state_next = S_KP_GO;
            end
            S_KP_GO:   state_next = S_KP_WAIT;
            S_KP_WAIT: if (div_stat.done) state_next = S_DM_MUL;
            S_DM_MUL:  state_next = S_DD_GO;
            S_DD_GO:   state_next = S_DD_WAIT;
            S_DD_WAIT: begin
                if (div_stat.done) state_next = (hc == '0) ? wave_end_st : S_H_RD;
            end
            S_H_RD:    state_next = S_H_RES;
            S_H_RES: begin
                if (hit)         state_next = S_OUT;
                else if (h_last) state_next = wave_end_st;
                else             state_next = S_H_RD;
            end
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            qm_reg      <= 32'sd65536;
            mass_reg    <= 31'd65536;
            hcount_reg  <= 4'd1;
            freq_a_reg  <= '0;
            freq_b_reg  <= '0;
            mode_a_reg  <= '0;
            mode_b_reg  <= '0;
            sq_idx_reg  <= '0;
            w_reg       <= 1'b0;
            hidx_reg    <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) hist_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            prod_reg  <= mul_full[63:0];

            if (cfg_valid) begin
                unique case (crc_reg_t'(cfg_index))
                    REG_QM:     qm_reg     <= cfg_data;
                    REG_MASS:   mass_reg   <= cfg_data[30:0];
                    REG_HCOUNT: hcount_reg <= cfg_data[3:0];
                    REG_FREQ_A: freq_a_reg <= cfg_data;
                    REG_FREQ_B: freq_b_reg <= cfg_data;
                    REG_MODE_A: mode_a_reg <= cfg_data[7:0];
                    REG_MODE_B: mode_b_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            // output register: load when free, drop after the transfer
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                m_kick_reg  <= res_kick_reg;
                m_level_reg <= res_level_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg     <= crc_cmd_t'(s_command);
                        fld_reg[0]  <= s_field_radial;
                        fld_reg[1]  <= s_field_toroidal;
                        fld_reg[2]  <= s_field_vertical;
                        radius_reg  <= s_major_radius;
                        ppar_reg    <= s_parallel_momentum;
                        wave_in_reg <= s_wave_index;
                        sq_idx_reg  <= '0;
                        sum_reg     <= '0;
                    end
                end
                S_ACC: begin
                    sum_reg    <= sum_reg + 64'(prod_reg);
                    sq_idx_reg <= sq_idx_reg + 2'd1;
                end
                S_RT_WAIT: begin
                    if (rt_stat.done) begin
                        b_reg <= rt_root[31] ? 32'h7FFF_FFFF : rt_root;
                        if (cmd_reg == CMD_PUSH) begin
                            for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                                hist_reg[i] <= hist_reg[i-1];
                            hist_reg[0] <= rt_root[31] ? 32'h7FFF_FFFF : rt_root;
                        end else if (cmd_reg == CMD_INIT) begin
                            for (int i = 0; i < HISTORY_DEPTH; i++)
                                hist_reg[i] <= rt_root[31] ? 32'h7FFF_FFFF : rt_root;
                        end
                    end
                end
                S_QB_SHF: begin
                    // truncate toward zero on the divide by 65536
                    qb_reg        <= prod_reg[63] ? 48'((prod_reg + 64'sd65535) >>> 16)
                                                  : 48'(prod_reg >>> 16);
                    w_reg         <= (cmd_reg == CMD_INIT) ? 1'b0 : wave_in_reg;
                    res_kick_reg  <= 2'd0;
                    res_level_reg <= 5'h1F;
                end
                S_KP_GO:   div_neg_reg <= mode_sel[7];
                S_KP_WAIT: if (div_stat.done) kpara_reg <= sat_quot(div_quot, div_neg_reg);
                S_DD_GO:   div_neg_reg <= prod_reg[63];
                S_DD_WAIT: begin
                    if (div_stat.done) begin
                        dop_reg  <= sat_quot(div_quot, div_neg_reg);
                        lqb_reg  <= '0;
                        hidx_reg <= '0;
                        if (hc == '0) w_reg <= w_reg + 1'b1;
                    end
                end
                S_H_RD: begin
                    lqb_reg <= lqb_reg + 52'(qb_reg);
                end
                S_H_RES: begin
                    if (hit) begin
                        res_kick_reg  <= flipped(pp_reg, pc) ? 2'd2 : 2'd1;
                        res_level_reg <= 5'(hidx_reg + HC_W'(1));
                    end else begin
                        hidx_reg <= hidx_reg + HC_W'(1);
                        if (h_last) w_reg <= w_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // resonance tables: one write and one registered read per cycle each
    always_ff @(posedge aclk) begin
        if (state_reg == S_H_RD) begin
            np_reg <= minus_tbl[tbl_idx];
            pp_reg <= plus_tbl[tbl_idx];
        end
        if (state_reg == S_H_RES) begin
            minus_tbl[tbl_idx] <= nc;
            plus_tbl[tbl_idx]  <= pc;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kick_count      = m_kick_reg;
    assign m_resonance_level = m_level_reg;

`ifndef ASSERT_OFF
    a_level_matches_kick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kick_count == 2'd0) == (m_resonance_level == 5'sh1F)))
        else $error("resonance level disagrees with kick count");

    a_kick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kick_count != 2'd3))
        else $error("kick count out of range");

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_harmonic_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_H_RES) |-> (hidx_reg < hc))
        else $error("harmonic index past harmonic count");
`endif

endmodule

[sv/crc_sqrt.sv]
module crc_sqrt
    import crc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [RADICAND_W-1:0] radicand,
    output crc_unit_st_t          stat,
    output logic [ROOT_W-1:0]     root
);

    logic [RADICAND_W-1:0] n_reg;
    logic [RADICAND_W-1:0] r_reg;
    logic [RADICAND_W-1:0] bit_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [RADICAND_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    // one result bit per cycle, digit pair by digit pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                n_reg    <= radicand;
                r_reg    <= '0;
                bit_reg  <= RADICAND_W'(1) << (RADICAND_W - 2);
            end else if (busy_reg) begin
                if (n_reg >= trial) begin
                    n_reg <= n_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = r_reg[ROOT_W-1:0];

endmodule

[sv/crc_div.sv]
module crc_div
    import crc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output crc_unit_st_t          stat,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  fits;

    assign rem_sh = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? DIVISOR_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

[tb/cyclotron_resonance_crossing_core_tb.sv]
module cyclotron_resonance_crossing_core_tb;
    import crc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = WAVE_COUNT_DEF * MAX_HARM_DEF;
    localparam int DRAIN_CYCLES = 400;      // covers the longest initialize
    localparam int WATCHDOG_LIMIT = 5000;   // cycles without a single transfer
    localparam int ITEMS_PER_PHASE = 130;
    localparam int RANDOM_PHASES = 8;
    localparam logic signed [4:0] NO_LEVEL = -5'sd1;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_command;
    logic               s_running;
    logic signed [31:0] s_field_radial;
    logic signed [31:0] s_field_toroidal;
    logic signed [31:0] s_field_vertical;
    logic [30:0]        s_major_radius;
    logic signed [31:0] s_parallel_momentum;
    logic               s_wave_index;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_kick_count;
    logic signed [4:0]  m_resonance_level;

    cyclotron_resonance_crossing_core dut (.*);

    // One input transfer, and one directed row with an optional hand-typed result.
    typedef struct {
        crc_cmd_t           cmd;
        logic               running;
        logic signed [31:0] b_rad;
        logic signed [31:0] b_tor;
        logic signed [31:0] b_ver;
        logic [30:0]        radius;
        logic signed [31:0] ppar;
        logic               wave;
    } marker_item_t;

    typedef struct {
        marker_item_t       item;
        bit                 typed;
        logic [1:0]         kicks;
        logic signed [4:0]  level;
    } directed_row_t;

    typedef struct {
        logic [1:0]        kicks;
        logic signed [4:0] level;
    } crossing_t;

    crossing_t pending_crossings[$];

    // Tracker state mirrored on the bench side
    longint      qm_reg, mass_reg, hcount_reg;
    longint      freq_reg[2];
    longint      mode_reg[2];
    logic [31:0] bmag_hist[3];
    longint      minus_tab[TABLE_SLOTS];
    longint      plus_tab[TABLE_SLOTS];

    int  mismatch_count;
    int  idle_cycles;
    int  ready_stall;
    bit  no_idling;

    // Clock: 10 ns period
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // |B| = floor(sqrt(sum of raw squares)), capped at the largest positive word
    function automatic logic [31:0] field_magnitude(logic signed [31:0] br,
                                                    logic signed [31:0] bt,
                                                    logic signed [31:0] bv);
        longint unsigned comp[3];
        longint unsigned n, root, bit_w;
        comp[0] = (br < 0) ? 64'(-longint'(br)) : 64'(longint'(br));
        comp[1] = (bt < 0) ? 64'(-longint'(bt)) : 64'(longint'(bt));
        comp[2] = (bv < 0) ? 64'(-longint'(bv)) : 64'(longint'(bv));
        n = comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2];
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w >>= 2;
        while (bit_w != 0) begin
            if (n >= root + bit_w) begin
                n -= root + bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return (root > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : root[31:0];
    endfunction

    function automatic longint doppler_shift(int wave, logic [30:0] radius,
                                             logic signed [31:0] ppar);
        longint r, m, kpara;
        r = longint'({33'd0, radius});
        m = mass_reg;
        if (r == 0) r = 1;
        if (m == 0) m = 1;
        kpara = clamp32((mode_reg[wave] * 64'sd4294967296) / r);
        return clamp32((kpara * longint'(ppar)) / m);
    endfunction

    function automatic longint resonance_value(int wave, longint harm, logic [31:0] bmag,
                                               longint dop, bit plus);
        longint lqb;
        lqb = (qm_reg * longint'({32'd0, bmag})) / 65536 * harm;
        return clamp32(freq_reg[wave] - lqb + (plus ? dop : -dop));
    endfunction

    function automatic bit sign_change(longint a, longint b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    // Advance the mirrored tracker by one command; report whether a result follows.
    task automatic track_marker(input marker_item_t it, output bit produces,
                                output crossing_t res);
        logic [31:0] bmag;
        longint      hc, dop, next_minus, next_plus;
        int          w, k;
        bmag = field_magnitude(it.b_rad, it.b_tor, it.b_ver);
        hc = (hcount_reg > MAX_HARM_DEF) ? MAX_HARM_DEF : hcount_reg;
        produces = 1'b0;
        res.kicks = 2'd0;
        res.level = NO_LEVEL;
        case (it.cmd)
            CMD_INIT: begin
                if (it.running) begin
                    foreach (bmag_hist[i]) bmag_hist[i] = bmag;
                    for (w = 0; w < WAVE_COUNT_DEF; w++) begin
                        dop = doppler_shift(w, it.radius, it.ppar);
                        for (int j = 0; j < hc; j++) begin
                            minus_tab[w * MAX_HARM_DEF + j] =
                                resonance_value(w, j + 1, bmag, dop, 1'b0);
                            plus_tab[w * MAX_HARM_DEF + j] =
                                resonance_value(w, j + 1, bmag, dop, 1'b1);
                        end
                    end
                end
            end
            CMD_PUSH: begin
                bmag_hist[2] = bmag_hist[1];
                bmag_hist[1] = bmag_hist[0];
                bmag_hist[0] = bmag;
            end
            CMD_EVAL: begin
                produces = 1'b1;
                // a still history leaves everything as it is
                if (!(bmag_hist[0] == bmag_hist[1] && bmag_hist[1] == bmag_hist[2])) begin
                    w = it.wave;
                    dop = doppler_shift(w, it.radius, it.ppar);
                    for (int j = 0; j < hc; j++) begin
                        k = w * MAX_HARM_DEF + j;
                        next_minus = resonance_value(w, j + 1, bmag, dop, 1'b0);
                        next_plus = resonance_value(w, j + 1, bmag, dop, 1'b1);
                        if (sign_change(minus_tab[k], next_minus)) begin
                            res.kicks = sign_change(plus_tab[k], next_plus) ? 2'd2 : 2'd1;
                            res.level = 5'(j + 1);
                            minus_tab[k] = next_minus;
                            plus_tab[k] = next_plus;
                            break;
                        end
                        minus_tab[k] = next_minus;
                        plus_tab[k] = next_plus;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Write one register while the block is idle, and mirror it.
    task automatic write_register(input crc_reg_t idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_QM:     qm_reg = longint'(signed'(value));
            REG_MASS:   mass_reg = longint'({33'd0, value[30:0]});
            REG_HCOUNT: hcount_reg = longint'(value[3:0]);
            REG_FREQ_A: freq_reg[0] = longint'(signed'(value));
            REG_FREQ_B: freq_reg[1] = longint'(signed'(value));
            REG_MODE_A: mode_reg[0] = longint'(signed'(value[7:0]));
            REG_MODE_B: mode_reg[1] = longint'(signed'(value[7:0]));
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [31:0] qm, input logic [31:0] mass,
                             input logic [31:0] hc, input logic [31:0] fa,
                             input logic [31:0] fb, input logic [31:0] ma,
                             input logic [31:0] mb);
        write_register(REG_QM, qm);
        write_register(REG_MASS, mass);
        write_register(REG_HCOUNT, hc);
        write_register(REG_FREQ_A, fa);
        write_register(REG_FREQ_B, fb);
        write_register(REG_MODE_A, ma);
        write_register(REG_MODE_B, mb);
    endtask

    // Present one item, hold it until the transfer, then queue what it causes.
    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_item(input marker_item_t it, input bit typed,
                             input crossing_t typed_res);
        int        gap;
        bit        produces;
        crossing_t res;
        gap = no_idling ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_command = it.cmd;
        s_running = it.running;
        s_field_radial = it.b_rad;
        s_field_toroidal = it.b_tor;
        s_field_vertical = it.b_ver;
        s_major_radius = it.radius;
        s_parallel_momentum = it.ppar;
        s_wave_index = it.wave;
        do @(posedge aclk); while (!s_ready);
        track_marker(it, produces, res);
        if (produces) pending_crossings.push_back(typed ? typed_res : res);
        @(negedge aclk);
    endtask

    // Drop valid at once, hold until every result is in, then let trailing
    // dropped items finish.
    task automatic drain;
        s_valid = 1'b0;
        while (pending_crossings.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic signed [31:0] field_word(bit wide);
        if (wide) return $urandom;
        return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
    endfunction

    // Mostly physical markers near resonance, the rest raw noise on every bit.
    function automatic marker_item_t random_item();
        marker_item_t it;
        int           pick;
        bit           wide;
        pick = $urandom_range(0, 99);
        wide = ($urandom_range(0, 3) == 0);
        if (pick < 10) it.cmd = CMD_INIT;
        else if (pick < 50) it.cmd = CMD_PUSH;
        else if (pick < 92) it.cmd = CMD_EVAL;
        else it.cmd = CMD_NONE;
        it.running = ($urandom_range(0, 4) != 0);
        it.b_rad = field_word(wide);
        it.b_tor = field_word(wide);
        it.b_ver = field_word(wide);
        it.radius = wide ? 31'($urandom) : 31'($urandom_range(16384, 4 * 65536));
        it.ppar = wide ? $urandom : $signed($urandom_range(0, 4 * 65536)) - 32'sd131072;
        it.wave = $urandom_range(0, 1);
        return it;
    endfunction

    // Result side: stall a random number of cycles before taking each result.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (ready_stall > 0) begin
            m_ready = 1'b0;
            ready_stall--;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Compare each result with the oldest expectation; watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("cyclotron_resonance_crossing_core verification failed");
                $finish;
            end
            if (m_valid && m_ready) begin
                ready_stall = no_idling ? 0 : $urandom_range(0, 3);
                if (pending_crossings.size() == 0) begin
                    note_mismatch("result with nothing expected");
                end else begin
                    crossing_t want;
                    want = pending_crossings.pop_front();
                    if (m_kick_count !== want.kicks)
                        note_mismatch($sformatf("kick_count expected %0d got %0d",
                                                want.kicks, m_kick_count));
                    if (m_resonance_level !== want.level)
                        note_mismatch($sformatf("resonance_level expected %0d got %0d",
                                                want.level, m_resonance_level));
                end
            end
        end
    end

    initial begin
        directed_row_t rows[$];
        directed_row_t row;
        crossing_t     typed_res;
        logic [31:0]   qm, mass, fa, fb;

        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_command = CMD_NONE;
        s_running = 1'b0;
        s_field_radial = '0;
        s_field_toroidal = '0;
        s_field_vertical = '0;
        s_major_radius = 31'd65536;
        s_parallel_momentum = '0;
        s_wave_index = 1'b0;
        m_ready = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        ready_stall = 0;
        no_idling = 1'b0;

        // reset defaults of the mirror
        qm_reg = 65536;
        mass_reg = 65536;
        hcount_reg = 1;
        freq_reg = '{0, 0};
        mode_reg = '{0, 0};
        bmag_hist = '{0, 0, 0};
        foreach (minus_tab[i]) begin
            minus_tab[i] = 0;
            plus_tab[i] = 0;
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: all harmonics on so the first running initialize fills both tables.
        write_all(32'h0001_0000, 32'h0001_0000, 32'd8, 32'h0005_0000, 32'h0002_8000,
                  32'd3, 32'hFFFF_FFFE);
        rows = '{
            // not running: initialize drops the item
            '{'{CMD_INIT, 1'b0, 32'sd196608, 32'sd262144, 0, 31'd65536, 0, 1'b0},
              0, 2'd0, NO_LEVEL},
            // unused command code
            '{'{CMD_NONE, 1'b1, 32'sd65536, 0, 0, 31'd65536, 0, 1'b0}, 0, 2'd0, NO_LEVEL},
            // |B| = 5.0 fills history and tables
            '{'{CMD_INIT, 1'b1, 32'sd196608, 32'sd262144, 0, 31'd65536, 32'sd65536, 1'b0},
              0, 2'd0, NO_LEVEL},
            // still history: no kick, level -1
            '{'{CMD_EVAL, 1'b0, 32'sd65536, 0, 0, 31'd65536, 0, 1'b0}, 1, 2'd0, NO_LEVEL},
            '{'{CMD_EVAL, 1'b1, 32'sd65536, 0, 0, 31'd65536, 0, 1'b1}, 1, 2'd0, NO_LEVEL},
            // push ignores running; largest components saturate |B|
            '{'{CMD_PUSH, 1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0}, 0, 2'd0, NO_LEVEL},
            '{'{CMD_EVAL, 1'b1, 32'sd65536, 0, 0, 31'd1, 32'sh7FFF_FFFF, 1'b0},
              0, 2'd0, NO_LEVEL},
            '{'{CMD_EVAL, 1'b1, 32'sd131072, 0, 0, 31'd1, 32'sh8000_0000, 1'b1},
              0, 2'd0, NO_LEVEL},
            '{'{CMD_PUSH, 1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                31'd1, 32'sh8000_0000, 1'b1}, 0, 2'd0, NO_LEVEL},
            '{'{CMD_PUSH, 1'b1, 0, 0, 0, 31'd1, 0, 1'b0}, 0, 2'd0, NO_LEVEL},
            // radius of zero counts as one LSB
            '{'{CMD_EVAL, 1'b1, 0, 32'sd655360, 0, 31'd0, 32'sd65536, 1'b0},
              0, 2'd0, NO_LEVEL},
            '{'{CMD_EVAL, 1'b0, 32'sh8000_0000, 0, 0, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1},
              0, 2'd0, NO_LEVEL},
            '{'{CMD_PUSH, 1'b1, 0, 32'sd32768, 0, 31'd65536, 0, 1'b0}, 0, 2'd0, NO_LEVEL},
            '{'{CMD_EVAL, 1'b1, 0, 32'sd327680, 0, 31'd65536, 32'sd16384, 1'b0},
              0, 2'd0, NO_LEVEL},
            '{'{CMD_EVAL, 1'b1, 0, 32'sd98304, 0, 31'd65536, -32'sd16384, 1'b1},
              0, 2'd0, NO_LEVEL},
            // zero field, zero momentum
            '{'{CMD_INIT, 1'b1, 0, 0, 0, 31'd1, 0, 1'b1}, 0, 2'd0, NO_LEVEL},
            '{'{CMD_EVAL, 1'b1, 0, 0, 0, 31'd1, 0, 1'b0}, 1, 2'd0, NO_LEVEL},
            // extreme initialize, then a still-history check on it
            '{'{CMD_INIT, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                31'h7FFF_FFFF, 32'sh8000_0000, 1'b0}, 0, 2'd0, NO_LEVEL},
            '{'{CMD_EVAL, 1'b1, 0, 0, 0, 31'd65536, 0, 1'b0}, 1, 2'd0, NO_LEVEL}
        };
        @(negedge aclk);
        foreach (rows[i]) begin
            typed_res.kicks = rows[i].kicks;
            typed_res.level = rows[i].level;
            send_item(rows[i].item, rows[i].typed, typed_res);
        end
        // sender pauses here until every result is back
        drain();

        // Random phases, each with its own register setting; the first two are extremes.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            no_idling = (p == 3);
            if (p == 0) begin
                write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd15, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'd127, 32'd127);
            end else if (p == 1) begin
                write_all(32'h8000_0000, 32'd1, 32'd0, 32'h8000_0000, 32'h8000_0000,
                          32'h80, 32'h80);
            end else begin
                qm = $urandom_range(16384, 2 * 65536);
                if ($urandom_range(0, 1)) qm = -qm;
                mass = (p == 2) ? 32'd0 : $urandom_range(32768, 2 * 65536);
                fa = $urandom_range(0, 24 * 65536);
                fb = $urandom_range(0, 24 * 65536);
                if (qm[31]) begin
                    fa = -fa;
                    fb = -fb;
                end
                write_all(qm, mass, $urandom_range(1, 8), fa, fb,
                          32'($signed($urandom_range(0, 16)) - 8),
                          32'($signed($urandom_range(0, 16)) - 8));
            end
            @(negedge aclk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(random_item(), 1'b0, typed_res);
            drain();
        end

        if (mismatch_count == 0 && pending_crossings.size() == 0) begin
            $display("cyclotron_resonance_crossing_core verification clean");
        end else begin
            $display("cyclotron_resonance_crossing_core verification failed");
        end
        $finish;
    end

endmodule

[files.f]
sv/crc_pkg.sv
sv/crc_sqrt.sv
sv/crc_div.sv
sv/cyclotron_resonance_crossing_core.sv
tb/cyclotron_resonance_crossing_core_tb.sv
